// ===== hdl/winograd_depthwise_3x3_tile_unit_defines.svh =====
// assertion macros for the winograd tile unit
`ifndef WINOGRAD_DEPTHWISE_3X3_TILE_UNIT_DEFINES_SVH
`define WINOGRAD_DEPTHWISE_3X3_TILE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WDT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define WDT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WDT_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define WDT_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/wdt_pkg.sv =====
package wdt_pkg;

    // default formats
    localparam int PIXEL_BITS_DEF  = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    // fixed field widths
    localparam int ROW_W    = 64;
    localparam int WROW_W   = 48;
    localparam int BIAS_W   = 16;
    localparam int OUT_W    = 16;
    localparam int OUT_FRAC = 8;

    // register port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    // register indexes
    localparam logic [1:0] REG_WEIGHTS_TOP    = 2'd0;
    localparam logic [1:0] REG_WEIGHTS_MIDDLE = 2'd1;
    localparam logic [1:0] REG_WEIGHTS_BOTTOM = 2'd2;
    localparam logic [1:0] REG_BIAS_VALUE     = 2'd3;

    // output clip bounds
    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

endpackage

// ===== hdl/winograd_depthwise_3x3_tile_unit.sv =====
// channel   direction  ports
// s_        in         s_valid, s_ready, s_tile_row0..s_tile_row3
// m_        out        m_valid, m_ready, m_y00, m_y01, m_y10, m_y11, m_saturated
// apb       in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// one tile per cycle unless m_ready stalls; a result is offered after its transfer has passed the
// input transform, multiply, output transform, and round and clip registers
// synchronous active-low reset clears the stage valid bits and the weight and bias registers
// a stall on m_ready holds each filled stage and backs up to s_ready
// the transformed kernel is registered in the cycle after a weight write
`include "winograd_depthwise_3x3_tile_unit_defines.svh"

module winograd_depthwise_3x3_tile_unit import wdt_pkg::*; #(
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ROW_W-1:0]        s_tile_row0,
    input  logic [ROW_W-1:0]        s_tile_row1,
    input  logic [ROW_W-1:0]        s_tile_row2,
    input  logic [ROW_W-1:0]        s_tile_row3,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_y00,
    output logic signed [OUT_W-1:0] m_y01,
    output logic signed [OUT_W-1:0] m_y10,
    output logic signed [OUT_W-1:0] m_y11,
    output logic                    m_saturated,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int UW = PIXEL_BITS + 2;
    localparam int KW = WEIGHT_BITS + 4;
    localparam int MW = PIXEL_BITS + WEIGHT_BITS + 6;
    localparam int YW = PIXEL_BITS + WEIGHT_BITS + 10;

    logic [ROW_W-1:0]        tile_rows [4];
    logic signed [KW-1:0]    k [16];
    logic signed [BIAS_W-1:0] bias;
    logic signed [UW-1:0]    u [16];
    logic signed [MW-1:0]    m [16];
    logic signed [YW-1:0]    y [4];
    logic signed [OUT_W-1:0] pix [4];
    logic                    in_ready;
    logic                    u_valid, u_ready;
    logic                    m_stage_valid, m_stage_ready;
    logic                    y_valid, y_ready;

    assign tile_rows[0] = s_tile_row0;
    assign tile_rows[1] = s_tile_row1;
    assign tile_rows[2] = s_tile_row2;
    assign tile_rows[3] = s_tile_row3;

    // no transfer while reset is held
    assign s_ready = in_ready && aresetn;

    // registers and kernel transform
    wdt_cfg_regs #(
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_cfg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .k      (k),
        .bias   (bias)
    );

    // stage 1: input transform
    wdt_in_xform #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_in_xform (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (in_ready),
        .tile_row (tile_rows),
        .out_valid(u_valid),
        .out_ready(u_ready),
        .u        (u)
    );

    // stage 2: elementwise multiply
    wdt_multiply #(
        .PIXEL_BITS (PIXEL_BITS),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_multiply (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (u_valid),
        .in_ready (u_ready),
        .u        (u),
        .k        (k),
        .out_valid(m_stage_valid),
        .out_ready(m_stage_ready),
        .m        (m)
    );

    // stage 3: output transform
    wdt_out_xform #(
        .PIXEL_BITS (PIXEL_BITS),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_out_xform (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (m_stage_valid),
        .in_ready (m_stage_ready),
        .m        (m),
        .out_valid(y_valid),
        .out_ready(y_ready),
        .y        (y)
    );

    // stage 4: bias, rounding, clipping
    wdt_round_sat #(
        .PIXEL_BITS (PIXEL_BITS),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_round_sat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (y_valid),
        .in_ready (y_ready),
        .y        (y),
        .bias     (bias),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .pix      (pix),
        .saturated(m_saturated)
    );

    assign m_y00 = pix[0];
    assign m_y01 = pix[1];
    assign m_y10 = pix[2];
    assign m_y11 = pix[3];

    // checks
    `WDT_ASSERT_IMP(a_sat_at_bound, aclk, aresetn, m_valid && m_saturated, m_y00 == OUT_MAX || m_y00 == OUT_MIN || m_y01 == OUT_MAX || m_y01 == OUT_MIN || m_y10 == OUT_MAX || m_y10 == OUT_MIN || m_y11 == OUT_MAX || m_y11 == OUT_MIN, "saturated flag without a clipped pixel")
    `WDT_ASSERT_NXT(a_transfer_fills, aclk, aresetn, s_valid && s_ready, u_valid, "input transfer did not fill the first stage")
    `WDT_ASSERT_IMP(a_full_when_blocked, aclk, aresetn, !in_ready, u_valid && m_stage_valid && y_valid && m_valid, "input blocked with an empty stage")

endmodule

// ===== hdl/wdt_cfg_regs.sv =====
module wdt_cfg_regs import wdt_pkg::*; #(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    output logic signed [WEIGHT_BITS+3:0] k [16],
    output logic signed [BIAS_W-1:0]      bias
);

    localparam int GW = WEIGHT_BITS;
    localparam int HW = WEIGHT_BITS + 2;
    localparam int KW = WEIGHT_BITS + 4;

    logic [WROW_W-1:0]   weights_reg [3];
    logic [BIAS_W-1:0]   bias_reg;
    logic [1:0]          reg_sel;
    logic                write_en;
    logic signed [GW-1:0] g  [3][3];
    logic signed [HW-1:0] kh [4][3];
    logic signed [KW-1:0] k_next [16];
    logic signed [KW-1:0] k_reg  [16];

    assign pready   = 1'b1;
    assign reg_sel  = paddr[APB_ADDR_W-1:3];
    assign write_en = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weights_reg[0] <= '0;
            weights_reg[1] <= '0;
            weights_reg[2] <= '0;
            bias_reg       <= '0;
        end else if (write_en) begin
            case (reg_sel)
                REG_WEIGHTS_TOP: begin
                    weights_reg[0] <= pwdata[WROW_W-1:0];
                end
                REG_WEIGHTS_MIDDLE: begin
                    weights_reg[1] <= pwdata[WROW_W-1:0];
                end
                REG_WEIGHTS_BOTTOM: begin
                    weights_reg[2] <= pwdata[WROW_W-1:0];
                end
                REG_BIAS_VALUE: begin
                    bias_reg <= pwdata[BIAS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_WEIGHTS_TOP:    prdata = APB_DATA_W'(weights_reg[0]);
            REG_WEIGHTS_MIDDLE: prdata = APB_DATA_W'(weights_reg[1]);
            REG_WEIGHTS_BOTTOM: prdata = APB_DATA_W'(weights_reg[2]);
            REG_BIAS_VALUE:     prdata = APB_DATA_W'(bias_reg);
            default:            prdata = '0;
        endcase
    end

    // kernel transform G g G^T, scaled by four so every half stays exact
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                g[r][c] = $signed(weights_reg[r][c*GW +: GW]);
            end
        end
        // columns
        for (int c = 0; c < 3; c++) begin
            kh[0][c] = HW'(g[0][c]) + HW'(g[0][c]);
            kh[1][c] = HW'(g[0][c]) + HW'(g[1][c]) + HW'(g[2][c]);
            kh[2][c] = HW'(g[0][c]) - HW'(g[1][c]) + HW'(g[2][c]);
            kh[3][c] = HW'(g[2][c]) + HW'(g[2][c]);
        end
        // rows
        for (int r = 0; r < 4; r++) begin
            k_next[r*4+0] = KW'(kh[r][0]) + KW'(kh[r][0]);
            k_next[r*4+1] = KW'(kh[r][0]) + KW'(kh[r][1]) + KW'(kh[r][2]);
            k_next[r*4+2] = KW'(kh[r][0]) - KW'(kh[r][1]) + KW'(kh[r][2]);
            k_next[r*4+3] = KW'(kh[r][2]) + KW'(kh[r][2]);
        end
    end

    // transformed kernel is registered, following the weight registers in the next cycle
    always_ff @(posedge aclk) begin
        k_reg <= k_next;
    end

    assign k    = k_reg;
    assign bias = $signed(bias_reg);

endmodule

// ===== hdl/wdt_in_xform.sv =====
module wdt_in_xform import wdt_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ROW_W-1:0]             tile_row [4],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [PIXEL_BITS+1:0] u [16]
);

    localparam int DW = PIXEL_BITS;
    localparam int CW = PIXEL_BITS + 1;
    localparam int UW = PIXEL_BITS + 2;

    logic signed [DW-1:0] d [4][4];
    logic signed [CW-1:0] t [4][4];
    logic signed [UW-1:0] u_next [16];
    logic signed [UW-1:0] u_reg  [16];
    logic                 valid_reg;

    // input transform B^T d B: columns, then rows
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                d[r][c] = $signed(tile_row[r][c*DW +: DW]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            t[0][c] = CW'(d[0][c]) - CW'(d[2][c]);
            t[1][c] = CW'(d[1][c]) + CW'(d[2][c]);
            t[2][c] = CW'(d[2][c]) - CW'(d[1][c]);
            t[3][c] = CW'(d[1][c]) - CW'(d[3][c]);
        end
        for (int r = 0; r < 4; r++) begin
            u_next[r*4+0] = UW'(t[r][0]) - UW'(t[r][2]);
            u_next[r*4+1] = UW'(t[r][1]) + UW'(t[r][2]);
            u_next[r*4+2] = UW'(t[r][2]) - UW'(t[r][1]);
            u_next[r*4+3] = UW'(t[r][1]) - UW'(t[r][3]);
        end
    end

    // stage handshake
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            u_reg <= u_next;
        end
    end

    assign u = u_reg;

endmodule

// ===== hdl/wdt_multiply.sv =====
module wdt_multiply import wdt_pkg::*; #(
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [PIXEL_BITS+1:0]             u [16],
    input  logic signed [WEIGHT_BITS+3:0]            k [16],
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [PIXEL_BITS+WEIGHT_BITS+5:0] m [16]
);

    localparam int MW = PIXEL_BITS + WEIGHT_BITS + 6;

    logic signed [MW-1:0] m_next [16];
    logic signed [MW-1:0] m_reg  [16];
    logic                 valid_reg;

    // elementwise product, one multiplier per lane
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            m_next[i] = MW'(u[i]) * MW'(k[i]);
        end
    end

    // stage handshake
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            m_reg <= m_next;
        end
    end

    assign m = m_reg;

endmodule

// ===== hdl/wdt_out_xform.sv =====
module wdt_out_xform import wdt_pkg::*; #(
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [PIXEL_BITS+WEIGHT_BITS+5:0] m [16],
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [PIXEL_BITS+WEIGHT_BITS+9:0] y [4]
);

    localparam int MW = PIXEL_BITS + WEIGHT_BITS + 6;
    localparam int SW = MW + 2;
    localparam int YW = MW + 4;

    logic signed [SW-1:0] s [2][4];
    logic signed [YW-1:0] y_next [4];
    logic signed [YW-1:0] y_reg  [4];
    logic                 valid_reg;

    // output transform A^T m A: rows of A^T, then columns
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s[0][c] = SW'(m[c]) + SW'(m[4+c]) + SW'(m[8+c]);
            s[1][c] = SW'(m[4+c]) - SW'(m[8+c]) - SW'(m[12+c]);
        end
        for (int r = 0; r < 2; r++) begin
            y_next[r*2+0] = YW'(s[r][0]) + YW'(s[r][1]) + YW'(s[r][2]);
            y_next[r*2+1] = YW'(s[r][1]) - YW'(s[r][2]) - YW'(s[r][3]);
        end
    end

    // stage handshake
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== hdl/wdt_round_sat.sv =====
module wdt_round_sat import wdt_pkg::*; #(
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [PIXEL_BITS+WEIGHT_BITS+9:0] y [4],
    input  logic signed [BIAS_W-1:0]                 bias,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [OUT_W-1:0]                  pix [4],
    output logic                                     saturated
);

    localparam int YW = PIXEL_BITS + WEIGHT_BITS + 10;
    localparam int AW = YW + 2;
    localparam int RS = PIXEL_BITS / 2 + (WEIGHT_BITS - 4) + 2 - OUT_FRAC;
    localparam int QW = AW - RS;

    localparam logic signed [AW-1:0] RND   = AW'(1) <<< (RS - 1);
    localparam logic signed [QW-1:0] Q_MAX = QW'(OUT_MAX);
    localparam logic signed [QW-1:0] Q_MIN = QW'(OUT_MIN);

    logic signed [AW-1:0]    bias_scaled;
    logic signed [AW-1:0]    v [4];
    logic signed [QW-1:0]    q [4];
    logic [3:0]              clip;
    logic signed [OUT_W-1:0] pix_next [4];
    logic signed [OUT_W-1:0] pix_reg  [4];
    logic                    sat_reg;
    logic                    valid_reg;

    // bias, round half-up, floor shift, clip
    always_comb begin
        bias_scaled = AW'(bias) <<< RS;
        for (int i = 0; i < 4; i++) begin
            v[i] = AW'(y[i]) + bias_scaled + RND;
            q[i] = QW'(v[i] >>> RS);
            if (q[i] > Q_MAX) begin
                pix_next[i] = OUT_MAX;
                clip[i]     = 1'b1;
            end else if (q[i] < Q_MIN) begin
                pix_next[i] = OUT_MIN;
                clip[i]     = 1'b1;
            end else begin
                pix_next[i] = q[i][OUT_W-1:0];
                clip[i]     = 1'b0;
            end
        end
    end

    // output register
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pix_reg <= pix_next;
            sat_reg <= |clip;
        end
    end

    assign pix       = pix_reg;
    assign saturated = sat_reg;

endmodule
